[hw/rtl/first_or_best_fit_block_allocator_defines.svh]
// Assertion macros used by the allocator top level.
`ifndef FIRST_OR_BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_OR_BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Check a property while out of reset.
`define FBFA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define FBFA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/fbfa_pkg.sv]
// Types and constants shared by the block allocator modules.
`timescale 1ns / 1ps

package fbfa_pkg;

  localparam int SIZE_W   = 20;
  localparam int OWNER_W  = 16;
  localparam int IDENT_W  = 4;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_GRANTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_INIT    = 2'd3;

  localparam logic REQ_INIT  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  localparam logic REG_MEMORY_SIZE  = 1'b0;
  localparam logic REG_FIT_STRATEGY = 1'b1;

  localparam logic [SIZE_W-1:0] MEMORY_SIZE_RESET = 20'd1024;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic               used;
    logic [OWNER_W-1:0] owner;
    logic [IDENT_W-1:0] ident;
  } entry_t;

endpackage

[hw/rtl/first_or_best_fit_block_allocator.sv]
// Top level of the first-fit / best-fit block allocator.
// Init request: writes entry 0 and goes to S_DONE. Allocate: scan one entry per cycle through a
// shared subtract/compare unit over the live entries (first-fit stops at its hit), then S_DECIDE
// refuses, or grants an exact fit through S_WRPOS; a split first does an upward shift of
// entry_count - pos - 1 words, then S_INSERT and S_WRPOS. Ready again as the result loads,
// once the previous word has left. rst is synchronous; S_CLEAR then writes entry 0.
`timescale 1ns / 1ps
`include "first_or_best_fit_block_allocator_defines.svh"

module first_or_best_fit_block_allocator #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [15:0] req_owner, [35:16] req_size, [39:36] zero
  input  logic [0:0]  s_tuser,   // [0] req_type
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] block_id, [23:4] found_size
  output logic [1:0]  m_tuser,   // [1:0] status
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import fbfa_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  // sequencer codes
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_INSERT = 3'd5;
  localparam logic [2:0] S_WRPOS  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]         state;

  // configuration registers
  logic [SIZE_W-1:0]  memory_size;
  logic               fit_strategy;

  // table bookkeeping
  logic [CW-1:0]      entry_count;

  // latched request
  logic [OWNER_W-1:0] req_owner;
  logic [SIZE_W-1:0]  req_size;

  // scan pipeline: issue address scan_idx, check the word read for chk_idx
  logic [CW-1:0]      scan_idx;
  logic               chk_valid;
  logic [IW-1:0]      chk_idx;

  // best candidate so far
  logic               best_found;
  logic [IW-1:0]      best_idx;
  logic [SIZE_W-1:0]  best_waste;
  logic [SIZE_W-1:0]  best_size;
  logic [IDENT_W-1:0] best_ident;

  // insert shift: read sh_rd, write the word one slot higher next cycle
  logic [IW-1:0]      sh_rd;
  logic [IW-1:0]      sh_wr;
  logic               sh_more;
  logic               sh_wvalid;

  // result held for the output register
  logic [STATUS_W-1:0] res_status;
  logic [IDENT_W-1:0]  res_ident;
  logic [SIZE_W-1:0]   res_size;

  // table port
  logic               tbl_we;
  logic [IW-1:0]      tbl_waddr;
  entry_t             tbl_wdata;
  logic [IW-1:0]      tbl_raddr;
  entry_t             tbl_rdata;

  // shared subtractor and its outcome
  logic [SIZE_W-1:0]  sub_a;
  logic [SIZE_W:0]    sub_diff;
  logic               fits;
  logic               better;
  logic               ff_hit;
  logic               issue;
  logic               in_accept;
  logic               out_free;

  fbfa_table #(
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // One subtractor serves both the fit test during the scan and the remainder at insert.
  assign sub_a    = (state == S_INSERT) ? best_size : tbl_rdata.size;
  assign sub_diff = {1'b0, sub_a} - {1'b0, req_size};
  assign fits     = !sub_diff[SIZE_W] && !tbl_rdata.used;
  assign better   = !best_found || (sub_diff[SIZE_W-1:0] < best_waste);
  assign ff_hit   = chk_valid && fits && (fit_strategy == FIT_FIRST);
  // Keep issuing reads until the live entries run out or first-fit has its block.
  assign issue    = (scan_idx < entry_count) && !ff_hit;

  // Table write and read selection.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = '0;
    tbl_wdata = '{size: memory_size, used: 1'b0, owner: '0, ident: '0};
    tbl_raddr = scan_idx[IW-1:0];
    unique case (state)
      S_CLEAR: begin
        tbl_we = 1'b1;
      end
      S_IDLE: begin
        tbl_we = in_accept && (s_tuser[0] == REQ_INIT);
      end
      S_SHIFT: begin
        tbl_raddr = sh_rd;
        tbl_we    = sh_wvalid;
        tbl_waddr = sh_wr;
        tbl_wdata = tbl_rdata;
      end
      S_INSERT: begin
        // Remainder becomes a fresh free block right after the chosen one.
        tbl_we    = 1'b1;
        tbl_waddr = best_idx + IW'(1);
        tbl_wdata = '{size: sub_diff[SIZE_W-1:0], used: 1'b0, owner: '0,
                      ident: IDENT_W'(entry_count)};
      end
      S_WRPOS: begin
        tbl_we    = 1'b1;
        tbl_waddr = best_idx;
        tbl_wdata = '{size: req_size, used: 1'b1, owner: req_owner, ident: best_ident};
      end
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      memory_size  <= MEMORY_SIZE_RESET;
      fit_strategy <= FIT_FIRST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index[0])
        REG_MEMORY_SIZE:  memory_size  <= cfg_data;
        REG_FIT_STRATEGY: fit_strategy <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      entry_count <= CW'(1);
      chk_valid   <= 1'b0;
      best_found  <= 1'b0;
      sh_more     <= 1'b0;
      sh_wvalid   <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_accept) begin
            if (s_tuser[0] == REQ_INIT) begin
              entry_count <= CW'(1);
              state       <= S_DONE;
            end else begin
              chk_valid  <= 1'b0;
              best_found <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (chk_valid && fits && better) begin
            best_found <= 1'b1;
          end
          chk_valid <= issue;
          if (!issue) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!best_found) begin
            state <= S_DONE;
          end else if (best_size != req_size) begin
            if (entry_count == CW'(MAX_BLOCKS)) begin
              state <= S_DONE;
            end else begin
              // Move entries above the chosen one up a slot, topmost first.
              sh_more   <= (best_idx != IW'(entry_count - CW'(1)));
              sh_wvalid <= 1'b0;
              state     <= S_SHIFT;
            end
          end else begin
            state <= S_WRPOS;
          end
        end
        S_SHIFT: begin
          sh_wvalid <= sh_more;
          if (sh_more) begin
            sh_more <= (sh_rd != best_idx + IW'(1));
          end
          if (!sh_more && !sh_wvalid) begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          entry_count <= entry_count + CW'(1);
          state       <= S_WRPOS;
        end
        S_WRPOS: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: request, scan pointers, best candidate, result.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        req_owner  <= s_tdata[15:0];
        req_size   <= s_tdata[35:16];
        scan_idx   <= '0;
        res_status <= STATUS_INIT;
        res_ident  <= '0;
        res_size   <= '0;
      end
      S_SCAN: begin
        if (chk_valid && fits && better) begin
          best_idx   <= chk_idx;
          best_waste <= sub_diff[SIZE_W-1:0];
          best_size  <= tbl_rdata.size;
          best_ident <= tbl_rdata.ident;
        end
        chk_idx  <= scan_idx[IW-1:0];
        scan_idx <= scan_idx + CW'(1);
      end
      S_DECIDE: begin
        sh_rd <= IW'(entry_count - CW'(1));
        if (!best_found) begin
          res_status <= STATUS_NOFIT;
        end else begin
          res_status <= STATUS_FULL;
          res_size   <= best_size;
        end
      end
      S_SHIFT: begin
        sh_wr <= sh_rd + IW'(1);
        if (sh_more) begin
          sh_rd <= sh_rd - IW'(1);
        end
      end
      S_WRPOS: begin
        res_status <= STATUS_GRANTED;
        res_ident  <= best_ident;
      end
      default: begin
      end
    endcase
  end

  // Output register: load the result once the previous word has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_tdata <= {res_size, res_ident};
      m_tuser <= res_status;
    end
  end

  `FBFA_ASSERT(a_count_range, (entry_count >= CW'(1)) && (entry_count <= CW'(MAX_BLOCKS)), "entry count out of range")
  `FBFA_ASSERT(a_insert_grows, (state == S_INSERT) |=> (entry_count == $past(entry_count) + CW'(1)), "insert did not grow the table")
  `FBFA_ASSERT(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready, "request taken while busy")
  `FBFA_ASSERT(a_full_only_when_full, ((state == S_DONE) && (res_status == STATUS_FULL)) |-> (entry_count == CW'(MAX_BLOCKS)), "table-full status with room left")

endmodule

[hw/rtl/fbfa_table.sv]
// Block table storage: one write port, one registered read port.
`timescale 1ns / 1ps

module fbfa_table #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  fbfa_pkg::entry_t           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output fbfa_pkg::entry_t           rdata
);
  import fbfa_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
